FILE: sv/tle_pkg.sv
// shared types and constants of the terminal line editor with history
// no dependencies
`default_nettype none

package tle_pkg;

  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_PMIN = 8'd32;
  localparam logic [7:0] CH_PMAX = 8'd127;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NORMAL = 2'd0;
  localparam mode_t MODE_WAIT2  = 2'd1;
  localparam mode_t MODE_WAIT3  = 2'd2;

  typedef logic [2:0] act_t;
  localparam act_t ACT_NONE  = 3'd0;
  localparam act_t ACT_PRINT = 3'd1;
  localparam act_t ACT_BS    = 3'd2;
  localparam act_t ACT_CR    = 3'd3;
  localparam act_t ACT_F1    = 3'd4;
  localparam act_t ACT_F3    = 3'd5;
  localparam act_t ACT_UP    = 3'd6;
  localparam act_t ACT_DOWN  = 3'd7;

  typedef logic [3:0] st_t;
  localparam st_t S_IDLE   = 4'd0;
  localparam st_t S_PROMPT = 4'd1;
  localparam st_t S_ACT    = 4'd2;
  localparam st_t S_ECHO   = 4'd3;
  localparam st_t S_BS     = 4'd4;
  localparam st_t S_ERASE  = 4'd5;
  localparam st_t S_RRD    = 4'd6;
  localparam st_t S_REMIT  = 4'd7;
  localparam st_t S_CR     = 4'd8;
  localparam st_t S_LF     = 4'd9;
  localparam st_t S_CRD    = 4'd10;
  localparam st_t S_CEMIT  = 4'd11;
  localparam st_t S_GT     = 4'd12;
  localparam st_t S_FIN    = 4'd13;

endpackage

`default_nettype wire

FILE: sv/terminal_line_editor_history.sv
// terminal line editor with a ring of past lines, top level; depends on tle_pkg
// an accepted item goes to S_ACT, through S_PROMPT first while the prompt is pending; each
// byte is held back and reaches out_tvalid when the next byte or the final flush follows;
// copied or recalled bytes each take a memory read state first, and stalls hold the block
// throughput: one item at a time; in_tready is high only while the sequencer is idle
// reset (sync, rst_n low): line empty, history lengths zero, prompt pending, timeout 500
`default_nettype none

module terminal_line_editor_history #(
  parameter int LINE_CHARS    = 16,
  parameter int HISTORY_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input items
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  input  wire logic       in_tuser,   // [0] cmd (1 = poll tick)
  // results
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // [0] to_consumer
  output logic            out_tlast,
  // configuration: escape_timeout
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import tle_pkg::*;

  localparam int LW  = $clog2(LINE_CHARS + 1);                     // length width
  localparam int IW  = $clog2(LINE_CHARS);                         // line index width
  localparam int SW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int HA  = (HISTORY_DEPTH * LINE_CHARS > 1) ?
                       $clog2(HISTORY_DEPTH * LINE_CHARS) : 1;
  localparam logic [LW-1:0] LC = LW'(LINE_CHARS);
  localparam logic [CW-1:0] HD = CW'(HISTORY_DEPTH);

  // memories
  logic [7:0] line_mem [LINE_CHARS];
  logic [7:0] hist_mem [HISTORY_DEPTH * LINE_CHARS];
  logic [7:0] line_rdata, hist_rdata;

  // control state
  st_t              st_r, st_nxt;
  mode_t            mode_r, mode_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [15:0]      timeout_r;
  logic [7:0]       sec_r, sec_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    hlen_r [HISTORY_DEPTH];
  logic [SW-1:0]    wslot_r, wslot_nxt;
  logic [SW-1:0]    vslot_r, vslot_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             prompt_r, prompt_nxt;

  // per-item working registers
  act_t             act_r, act_nxt;
  logic [7:0]       b_r, b_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic [LW-1:0]    ecnt_r, ecnt_nxt;   // characters left to erase
  logic [LW-1:0]    end_r, end_nxt;     // recall stops here
  logic [LW-1:0]    idx_r, idx_nxt;     // line copy index
  logic [SW-1:0]    rslot_r, rslot_nxt; // slot being read or written

  // one byte held back so the final one can carry tlast
  logic             pend_v_r;
  logic [7:0]       pend_b_r;
  logic             pend_c_r;

  logic             out_free;
  logic             gen, gen_c, flush;
  logic [7:0]       gen_b;
  logic             lwe, hwe, lre, hre, hlen_we;
  logic [IW-1:0]    lwa, lra;
  logic [7:0]       lwd, hwd;
  logic [HA-1:0]    hwa, hra;
  logic             in_acc;
  logic [SW-1:0]    top;
  logic [LW-1:0]    vlen;

  assign out_free  = !out_tvalid || out_tready;
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign top       = (cnt_r != '0) ? SW'(cnt_r - 1'b1) : '0;
  assign vlen      = hlen_r[vslot_r];

  function automatic logic [HA-1:0] haddr(input logic [SW-1:0] s, input logic [LW-1:0] i);
    haddr = HA'(s * LINE_CHARS) + HA'(i);
  endfunction

  always_comb begin
    st_nxt = st_r; mode_nxt = mode_r; timer_nxt = timer_r; sec_nxt = sec_r;
    len_nxt = len_r; wslot_nxt = wslot_r; vslot_nxt = vslot_r; cnt_nxt = cnt_r;
    prompt_nxt = prompt_r; act_nxt = act_r; b_nxt = b_r; sub_nxt = sub_r;
    ecnt_nxt = ecnt_r; end_nxt = end_r; idx_nxt = idx_r; rslot_nxt = rslot_r;
    gen = 1'b0; gen_b = '0; gen_c = 1'b0; flush = 1'b0;
    lwe = 1'b0; lwa = '0; lwd = '0; lre = 1'b0; lra = '0;
    hwe = 1'b0; hwa = '0; hwd = '0; hre = 1'b0; hra = '0; hlen_we = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt = ACT_NONE;
          b_nxt   = in_tdata;
          if (mode_r != MODE_NORMAL) begin
            priority if (timer_r >= timeout_r) begin
              // wait timed out: drop it, a byte is then handled as normal input
              mode_nxt  = MODE_NORMAL;
              timer_nxt = '0;
              if (!in_tuser) act_nxt = ACT_PRINT;  // classified below
            end else if (in_tuser) begin
              timer_nxt = timer_r + 16'd1;
            end else if (mode_r == MODE_WAIT2) begin
              sec_nxt   = in_tdata;
              timer_nxt = '0;
              mode_nxt  = MODE_WAIT3;
            end else begin
              timer_nxt = '0;
              mode_nxt  = MODE_NORMAL;
              priority if (sec_r == CH_O && in_tdata == CH_P)     act_nxt = ACT_F1;
              else if (sec_r == CH_O && in_tdata == CH_R)         act_nxt = ACT_F3;
              else if (sec_r == CH_LBR && in_tdata == CH_A)       act_nxt = ACT_UP;
              else if (sec_r == CH_LBR && in_tdata == CH_B)       act_nxt = ACT_DOWN;
              else                                                act_nxt = ACT_NONE;
            end
          end else if (!in_tuser) begin
            act_nxt = ACT_PRINT;  // classified below
          end
          // classify a byte taken as normal input
          if (act_nxt == ACT_PRINT) begin
            priority if (in_tdata == CH_BS) act_nxt = ACT_BS;
            else if (in_tdata == CH_CR) act_nxt = ACT_CR;
            else if (in_tdata >= CH_PMIN && in_tdata <= CH_PMAX) act_nxt = ACT_PRINT;
            else begin
              act_nxt = ACT_NONE;
              if (in_tdata == CH_ESC) begin
                mode_nxt  = MODE_WAIT2;
                timer_nxt = '0;
              end
            end
          end
          st_nxt = prompt_r ? S_PROMPT : S_ACT;
        end
      end
      S_PROMPT: begin
        if (out_free) begin
          gen = 1'b1; gen_b = CH_GT;
          prompt_nxt = 1'b0;
          st_nxt = S_ACT;
        end
      end
      S_ACT: begin
        st_nxt = S_FIN;
        unique case (act_r)
          ACT_PRINT: if (len_r < LC) st_nxt = S_ECHO;
          ACT_BS: begin
            if (len_r != '0) begin
              len_nxt = len_r - 1'b1;
              sub_nxt = '0;
              st_nxt  = S_BS;
            end
          end
          ACT_CR: st_nxt = S_CR;
          ACT_F1, ACT_F3: begin
            if (len_r < vlen) begin
              end_nxt   = (act_r == ACT_F1) ? len_r + 1'b1 : vlen;
              rslot_nxt = vslot_r;
              st_nxt    = S_RRD;
            end
          end
          ACT_UP, ACT_DOWN: begin
            if (cnt_r != '0) begin
              end_nxt   = vlen;
              rslot_nxt = vslot_r;
              ecnt_nxt  = len_r;
              sub_nxt   = '0;
              if (len_r == '0) st_nxt = S_RRD;
              else             st_nxt = S_ERASE;
              if (act_r == ACT_UP) begin
                vslot_nxt = (vslot_r == '0) ? top : vslot_r - 1'b1;
              end else if (vslot_r == top || CW'(vslot_r) + 1'b1 >= HD) begin
                vslot_nxt = '0;
              end else begin
                vslot_nxt = vslot_r + 1'b1;
              end
            end
          end
          default: st_nxt = S_FIN;
        endcase
      end
      S_ECHO: begin
        if (out_free) begin
          gen = 1'b1; gen_b = b_r;
          lwe = 1'b1; lwa = len_r[IW-1:0]; lwd = b_r;
          len_nxt = len_r + 1'b1;
          st_nxt = S_FIN;
        end
      end
      S_BS: begin
        if (out_free) begin
          gen = 1'b1; gen_b = (sub_r == 2'd1) ? CH_SP : CH_BS;
          sub_nxt = sub_r + 2'd1;
          if (sub_r == 2'd2) st_nxt = S_FIN;
        end
      end
      S_ERASE: begin
        if (out_free) begin
          gen = 1'b1; gen_b = (sub_r == 2'd1) ? CH_SP : CH_BS;
          sub_nxt = sub_r + 2'd1;
          if (sub_r == 2'd2) begin
            sub_nxt  = '0;
            ecnt_nxt = ecnt_r - 1'b1;
            if (ecnt_r == LW'(1)) begin
              len_nxt = '0;
              st_nxt  = S_RRD;
            end
          end
        end
      end
      S_RRD: begin
        if (len_r < end_r && len_r < LC) begin
          hre = 1'b1; hra = haddr(rslot_r, len_r);
          st_nxt = S_REMIT;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_REMIT: begin
        if (out_free) begin
          gen = 1'b1; gen_b = hist_rdata;
          lwe = 1'b1; lwa = len_r[IW-1:0]; lwd = hist_rdata;
          len_nxt = len_r + 1'b1;
          st_nxt = S_RRD;
        end
      end
      S_CR: begin
        if (out_free) begin
          gen = 1'b1; gen_b = CH_CR;
          st_nxt = S_LF;
        end
      end
      S_LF: begin
        if (out_free) begin
          gen = 1'b1; gen_b = CH_LF;
          st_nxt = S_GT;
          if (len_r != '0) begin
            // save the line: bookkeeping now, bytes copied below
            hlen_we   = 1'b1;
            rslot_nxt = wslot_r;
            vslot_nxt = wslot_r;
            if (cnt_r < HD) cnt_nxt = cnt_r + 1'b1;
            wslot_nxt = (CW'(wslot_r) + 1'b1 >= HD) ? '0 : wslot_r + 1'b1;
            idx_nxt   = '0;
            st_nxt    = S_CRD;
          end
        end
      end
      S_CRD: begin
        if (idx_r < len_r) begin
          lre = 1'b1; lra = idx_r[IW-1:0];
          st_nxt = S_CEMIT;
        end else begin
          len_nxt = '0;
          st_nxt  = S_GT;
        end
      end
      S_CEMIT: begin
        if (out_free) begin
          gen = 1'b1; gen_b = line_rdata; gen_c = 1'b1;
          hwe = 1'b1; hwa = haddr(rslot_r, idx_r); hwd = line_rdata;
          idx_nxt = idx_r + 1'b1;
          st_nxt = S_CRD;
        end
      end
      S_GT: begin
        if (out_free) begin
          gen = 1'b1; gen_b = CH_GT;
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          st_nxt = S_IDLE;
        end else if (out_free) begin
          flush  = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // memories: registered synchronous reads
  always_ff @(posedge clk) begin
    if (lwe) line_mem[lwa] <= lwd;
    if (lre) line_rdata <= line_mem[lra];
    if (hwe) hist_mem[hwa] <= hwd;
    if (hre) hist_rdata <= hist_mem[hra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt; b_r <= b_nxt; sub_r <= sub_nxt; ecnt_r <= ecnt_nxt;
    end_r <= end_nxt; idx_r <= idx_nxt; rslot_r <= rslot_nxt;
    if (gen) begin
      pend_b_r <= gen_b;
      pend_c_r <= gen_c;
    end
    if ((gen && pend_v_r) || flush) begin
      out_tdata <= pend_b_r;
      out_tuser <= pend_c_r;
      out_tlast <= flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; mode_r <= MODE_NORMAL; timer_r <= '0; sec_r <= '0;
      len_r <= '0; wslot_r <= '0; vslot_r <= '0; cnt_r <= '0; prompt_r <= 1'b1;
      timeout_r <= TIMEOUT_RESET;
      pend_v_r <= 1'b0; out_tvalid <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hlen_r[i] <= '0;
    end else begin
      st_r <= st_nxt; mode_r <= mode_nxt; timer_r <= timer_nxt; sec_r <= sec_nxt;
      len_r <= len_nxt; wslot_r <= wslot_nxt; vslot_r <= vslot_nxt; cnt_r <= cnt_nxt;
      prompt_r <= prompt_nxt;
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      if (hlen_we) hlen_r[wslot_r] <= len_r;
      // held byte: set by each new byte, cleared on the final flush
      if (gen) pend_v_r <= 1'b1;
      else if (flush) pend_v_r <= 1'b0;
      // output register loads whenever the held byte moves out
      if ((gen && pend_v_r) || flush) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/terminal_line_editor_history_chk.sv
// port-level checker for terminal_line_editor_history, with its bind
// depends on terminal_line_editor_history ports only
`default_nettype none

module terminal_line_editor_history_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new item taken right after a transfer");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata >= 8'd32 && out_tdata <= 8'd127)
    else $error("non-printable byte sent to consumer");

endmodule

bind terminal_line_editor_history terminal_line_editor_history_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

`default_nettype wire
